>>> rtl/core/grba_pkg.sv
// shared types and constants of the grid rectangle block allocator
package grba_pkg;

    localparam int SIDE_MAX  = 16;
    localparam int CELLS     = SIDE_MAX * SIDE_MAX;
    localparam int ADDR_W    = $clog2(CELLS);
    localparam int COORD_W   = $clog2(SIDE_MAX);
    localparam int ID_W      = 8;
    localparam int SIDE_W    = 5;
    localparam int SIZE_W    = 5;
    localparam int STATUS_W  = 3;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_PLACED   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_SIZE = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FREED    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FREE_IGN = 3'd4;
    localparam logic [STATUS_W-1:0] ST_MISMATCH = 3'd5;

    localparam logic [SIDE_W-1:0] SIDE_RESET = 5'd16;

    // commands from the controller to the datapath
    typedef struct packed {
        logic                clr;
        logic                load;
        logic                walk_init;
        logic                hint_rd;
        logic                hint_clr;
        logic                walk_next;
        logic                cell_rd_hint;
        logic                fit_start_hint;
        logic                fit_start_scan;
        logic                scan_init;
        logic                scan_next;
        logic                cell_rd_rect;
        logic                rect_next;
        logic                rect_restart;
        logic                mark_wr;
        logic                place;
        logic                hint_set_right;
        logic                hint_set_below;
        logic                hint_set_free;
        logic                free_start;
        logic                free_wr;
        logic                set_status;
        logic [STATUS_W-1:0] status;
        logic                free_status;
        logic                emit;
    } t_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic clr_last;
        logic is_free;
        logic bad_size;
        logic bad_corner;
        logic walk_last;
        logic idx_ge_ss;
        logic hint_q;
        logic occ_q;
        logic placed;
        logic in_scan;
        logic rect_oob;
        logic rect_last;
        logic scan_last;
        logic right_ok;
        logic below_ok;
        logic out_free;
    } t_stat;

endpackage

>>> rtl/core/grba_dp.sv
// datapath: grid and hint memories, walk and scan counters, output register
module grba_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  grba_pkg::t_cmd                      i_cmd_bus,
    output grba_pkg::t_stat                     o_stat,
    input  logic                                i_cfg_we,
    input  logic [grba_pkg::SIDE_W-1:0]         i_cfg_data,
    input  logic                                i_cmd,
    input  logic [grba_pkg::SIZE_W-1:0]         i_width_blocks,
    input  logic [grba_pkg::SIZE_W-1:0]         i_height_blocks,
    input  logic signed [grba_pkg::SIZE_W-1:0]  i_free_x,
    input  logic signed [grba_pkg::SIZE_W-1:0]  i_free_y,
    input  logic [grba_pkg::ID_W-1:0]           i_owner_id,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic [grba_pkg::STATUS_W-1:0]       o_status,
    output logic [grba_pkg::COORD_W-1:0]        o_placed_x,
    output logic [grba_pkg::COORD_W-1:0]        o_placed_y
);
    import grba_pkg::*;

    localparam int CW = COORD_W;

    logic [ID_W:0]          r_cell_mem [CELLS];
    logic                   r_hint_mem [CELLS];
    logic [ID_W:0]          r_cell_q;
    logic                   r_hint_q;

    logic [SIDE_W-1:0]      r_side;
    logic [ADDR_W:0]        r_clr_idx;
    logic                   r_op;
    logic [SIZE_W-1:0]      r_w, r_h;
    logic [SIZE_W-1:0]      r_fx, r_fy;
    logic [ID_W-1:0]        r_id;
    logic [ADDR_W-1:0]      r_idx;
    logic [CW-1:0]          r_hx;
    logic [CW:0]            r_hy;
    logic [CW-1:0]          r_sx, r_sy;
    logic [CW-1:0]          r_bx, r_by, r_cx, r_cy;
    logic [CW-1:0]          r_px, r_py;
    logic                   r_placed, r_in_scan, r_mism;
    logic [STATUS_W-1:0]    r_status;
    logic                   r_ovalid;
    logic [STATUS_W-1:0]    r_ostatus;
    logic [CW-1:0]          r_opx, r_opy;

    logic [SIDE_W-1:0]      s;
    logic [2*SIDE_W-1:0]    ss;
    logic [SIZE_W:0]        xsum, ysum;
    logic [SIDE_W-1:0]      ex, ey;
    logic                   cx_end, cy_end;
    logic [2*SIDE_W-1:0]    right_addr, below_addr, free_addr;
    logic [SIZE_W:0]        pxw, pyh;
    logic                   cell_we, cell_re, hint_we, hint_re;
    logic [ADDR_W-1:0]      cell_wa, cell_ra, hint_wa;
    logic [ID_W:0]          cell_wd;
    logic                   hint_wd;

    // side in use, clamped to 1..16
    always_comb begin
        if (r_side == '0) begin
            s = SIDE_W'(1);
        end else if (r_side > SIDE_W'(SIDE_MAX)) begin
            s = SIDE_W'(SIDE_MAX);
        end else begin
            s = r_side;
        end
    end
    assign ss = (2*SIDE_W)'(s) * (2*SIDE_W)'(s);

    // rectangle extents, clipped to the grid
    assign xsum   = (SIZE_W+1)'(r_bx) + (SIZE_W+1)'(r_w);
    assign ysum   = (SIZE_W+1)'(r_by) + (SIZE_W+1)'(r_h);
    assign ex     = (xsum > (SIZE_W+1)'(s)) ? s : xsum[SIDE_W-1:0];
    assign ey     = (ysum > (SIZE_W+1)'(s)) ? s : ysum[SIDE_W-1:0];
    assign cx_end = (SIDE_W'(r_cx) + SIDE_W'(1)) == ex;
    assign cy_end = (SIDE_W'(r_cy) + SIDE_W'(1)) == ey;

    assign pxw        = (SIZE_W+1)'(r_px) + (SIZE_W+1)'(r_w);
    assign pyh        = (SIZE_W+1)'(r_py) + (SIZE_W+1)'(r_h);
    assign right_addr = (2*SIDE_W)'(r_py) * (2*SIDE_W)'(s) + (2*SIDE_W)'(pxw);
    assign below_addr = (2*SIDE_W)'(pyh) * (2*SIDE_W)'(s) + (2*SIDE_W)'(r_px);
    assign free_addr  = (2*SIDE_W)'(r_fy[CW-1:0]) * (2*SIDE_W)'(s)
                      + (2*SIDE_W)'(r_fx[CW-1:0]);

    // memory port muxing
    always_comb begin
        cell_we = i_cmd_bus.clr | i_cmd_bus.mark_wr | i_cmd_bus.free_wr;
        cell_wa = i_cmd_bus.clr ? r_clr_idx[ADDR_W-1:0] : {r_cy, r_cx};
        cell_wd = i_cmd_bus.mark_wr ? {1'b1, r_id} : '0;
        cell_re = i_cmd_bus.cell_rd_hint | i_cmd_bus.cell_rd_rect;
        cell_ra = i_cmd_bus.cell_rd_hint ? {r_hy[CW-1:0], r_hx} : {r_cy, r_cx};
        hint_re = i_cmd_bus.hint_rd;
        hint_we = 1'b1;
        hint_wd = 1'b1;
        hint_wa = r_idx;
        if (i_cmd_bus.clr) begin
            hint_wa = r_clr_idx[ADDR_W-1:0];
            hint_wd = 1'b0;
        end else if (i_cmd_bus.hint_clr) begin
            hint_wd = 1'b0;
        end else if (i_cmd_bus.hint_set_right) begin
            hint_wa = right_addr[ADDR_W-1:0];
        end else if (i_cmd_bus.hint_set_below) begin
            hint_wa = below_addr[ADDR_W-1:0];
        end else if (i_cmd_bus.hint_set_free) begin
            hint_wa = free_addr[ADDR_W-1:0];
        end else begin
            hint_we = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cell_we) begin
            r_cell_mem[cell_wa] <= cell_wd;
        end
        if (cell_re) begin
            r_cell_q <= r_cell_mem[cell_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (hint_we) begin
            r_hint_mem[hint_wa] <= hint_wd;
        end
        if (hint_re) begin
            r_hint_q <= r_hint_mem[r_idx];
        end
    end

    // control state of the datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side    <= SIDE_RESET;
            r_clr_idx <= '0;
            r_ovalid  <= 1'b0;
            r_placed  <= 1'b0;
            r_in_scan <= 1'b0;
            r_mism    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_side <= i_cfg_data;
            end
            if (i_cmd_bus.clr) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
            if (i_cmd_bus.emit) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            if (i_cmd_bus.walk_init) begin
                r_placed  <= 1'b0;
                r_in_scan <= 1'b0;
            end
            if (i_cmd_bus.scan_init) begin
                r_in_scan <= 1'b1;
            end
            if (i_cmd_bus.place) begin
                r_placed <= 1'b1;
            end
            if (i_cmd_bus.free_start) begin
                r_mism <= 1'b0;
            end else if (i_cmd_bus.free_wr && r_cell_q != {1'b1, r_id}) begin
                r_mism <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd_bus.load) begin
            r_op <= i_cmd;
            r_w  <= i_width_blocks;
            r_h  <= i_height_blocks;
            r_fx <= i_free_x;
            r_fy <= i_free_y;
            r_id <= i_owner_id;
            r_px <= '0;
            r_py <= '0;
        end
        if (i_cmd_bus.walk_init) begin
            r_idx <= '0;
            r_hx  <= '0;
            r_hy  <= '0;
        end else if (i_cmd_bus.walk_next) begin
            r_idx <= r_idx + 1'b1;
            if ({1'b0, r_idx} < ss[ADDR_W:0] || ss > (2*SIDE_W)'(CELLS)) begin
                if ((SIDE_W'(r_hx) + SIDE_W'(1)) == s) begin
                    r_hx <= '0;
                    r_hy <= r_hy + 1'b1;
                end else begin
                    r_hx <= r_hx + 1'b1;
                end
            end
        end
        if (i_cmd_bus.scan_init) begin
            r_sx <= '0;
            r_sy <= '0;
        end else if (i_cmd_bus.scan_next) begin
            if ((SIDE_W'(r_sy) + SIDE_W'(1)) == s) begin
                r_sy <= '0;
                r_sx <= r_sx + 1'b1;
            end else begin
                r_sy <= r_sy + 1'b1;
            end
        end
        if (i_cmd_bus.fit_start_hint) begin
            r_bx <= r_hx;
            r_by <= r_hy[CW-1:0];
            r_cx <= r_hx;
            r_cy <= r_hy[CW-1:0];
        end else if (i_cmd_bus.fit_start_scan) begin
            r_bx <= r_sx;
            r_by <= r_sy;
            r_cx <= r_sx;
            r_cy <= r_sy;
        end else if (i_cmd_bus.free_start) begin
            r_bx <= r_fx[CW-1:0];
            r_by <= r_fy[CW-1:0];
            r_cx <= r_fx[CW-1:0];
            r_cy <= r_fy[CW-1:0];
        end else if (i_cmd_bus.rect_restart) begin
            r_cx <= r_bx;
            r_cy <= r_by;
        end else if (i_cmd_bus.rect_next) begin
            if (cx_end) begin
                r_cx <= r_bx;
                r_cy <= r_cy + 1'b1;
            end else begin
                r_cx <= r_cx + 1'b1;
            end
        end
        if (i_cmd_bus.place) begin
            r_px <= r_bx;
            r_py <= r_by;
        end
        if (i_cmd_bus.set_status) begin
            r_status <= i_cmd_bus.status;
        end else if (i_cmd_bus.free_status) begin
            r_status <= r_mism ? ST_MISMATCH : ST_FREED;
        end
        if (i_cmd_bus.emit) begin
            r_ostatus <= r_status;
            r_opx     <= r_px;
            r_opy     <= r_py;
        end
    end

    always_comb begin
        o_stat.clr_last   = r_clr_idx[ADDR_W-1:0] == ADDR_W'(CELLS - 1);
        o_stat.is_free    = r_op == CMD_FREE;
        o_stat.bad_size   = (r_w == '0) || (r_h == '0);
        o_stat.bad_corner = r_fx[SIZE_W-1] || r_fy[SIZE_W-1] || (r_fx >= s) || (r_fy >= s);
        o_stat.walk_last  = r_idx == ADDR_W'(CELLS - 1);
        o_stat.idx_ge_ss  = (2*SIDE_W)'(r_idx) >= ss;
        o_stat.hint_q     = r_hint_q;
        o_stat.occ_q      = r_cell_q[ID_W];
        o_stat.placed     = r_placed;
        o_stat.in_scan    = r_in_scan;
        o_stat.rect_oob   = (xsum > (SIZE_W+1)'(s)) || (ysum > (SIZE_W+1)'(s));
        o_stat.rect_last  = cx_end && cy_end;
        o_stat.scan_last  = ((SIDE_W'(r_sx) + SIDE_W'(1)) == s)
                         && ((SIDE_W'(r_sy) + SIDE_W'(1)) == s);
        o_stat.right_ok   = pxw != (SIZE_W+1)'(s);
        o_stat.below_ok   = pyh != (SIZE_W+1)'(s);
        o_stat.out_free   = !r_ovalid || i_out_ready;
    end

    assign o_out_valid = r_ovalid;
    assign o_status    = r_ostatus;
    assign o_placed_x  = r_opx;
    assign o_placed_y  = r_opy;

    a_mark_in_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_bus.mark_wr |-> !o_stat.rect_oob)
        else $error("mark outside grid");
    a_emit_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_bus.emit |-> (!r_ovalid || i_out_ready))
        else $error("result overwritten");
    a_no_result_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_bus.clr |-> !r_ovalid)
        else $error("result during clearing pass");

endmodule

>>> rtl/core/grba_ctrl.sv
// controller state machine sequencing walk, fit, scan, mark and free
module grba_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  grba_pkg::t_stat i_stat,
    input  logic            i_req_valid,
    output logic            o_req_ready,
    output grba_pkg::t_cmd  o_cmd_bus
);
    import grba_pkg::*;

    typedef enum logic [15:0] {
        S_CLR      = 16'h0001,
        S_IDLE     = 16'h0002,
        S_DISP     = 16'h0004,
        S_HRD      = 16'h0008,
        S_HCHK     = 16'h0010,
        S_HOCC     = 16'h0020,
        S_FRD      = 16'h0040,
        S_FCHK     = 16'h0080,
        S_MARK     = 16'h0100,
        S_SCAN     = 16'h0200,
        S_HNT_R    = 16'h0400,
        S_HNT_B    = 16'h0800,
        S_FREE_RD  = 16'h1000,
        S_FREE_WR  = 16'h2000,
        S_FREE_HNT = 16'h4000,
        S_DONE     = 16'h8000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_req_ready = r_state == S_IDLE;

    always_comb begin
        o_cmd_bus = '0;
        n_state   = r_state;
        case (r_state)
            S_CLR: begin
                o_cmd_bus.clr = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd_bus.load = 1'b1;
                    n_state        = S_DISP;
                end
            end
            S_DISP: begin
                if (!i_stat.is_free) begin
                    if (i_stat.bad_size) begin
                        o_cmd_bus.set_status = 1'b1;
                        o_cmd_bus.status     = ST_BAD_SIZE;
                        n_state              = S_DONE;
                    end else begin
                        o_cmd_bus.walk_init = 1'b1;
                        n_state             = S_HRD;
                    end
                end else if (i_stat.bad_corner) begin
                    o_cmd_bus.set_status = 1'b1;
                    o_cmd_bus.status     = ST_FREE_IGN;
                    n_state              = S_DONE;
                end else if (i_stat.bad_size) begin
                    o_cmd_bus.set_status = 1'b1;
                    o_cmd_bus.status     = ST_BAD_SIZE;
                    n_state              = S_DONE;
                end else begin
                    o_cmd_bus.free_start = 1'b1;
                    n_state              = S_FREE_RD;
                end
            end
            S_HRD: begin
                o_cmd_bus.hint_rd = 1'b1;
                n_state           = S_HCHK;
            end
            S_HCHK, S_HOCC: begin
                if (r_state == S_HCHK && i_stat.hint_q && !i_stat.idx_ge_ss) begin
                    o_cmd_bus.cell_rd_hint = 1'b1;
                    n_state                = S_HOCC;
                end else if (r_state == S_HOCC && !i_stat.occ_q && !i_stat.placed) begin
                    o_cmd_bus.fit_start_hint = 1'b1;
                    n_state                  = S_FRD;
                end else begin
                    // drop stale or covered hint, then move on
                    o_cmd_bus.hint_clr = (r_state == S_HCHK) ? i_stat.hint_q : i_stat.occ_q;
                    if (!i_stat.walk_last) begin
                        o_cmd_bus.walk_next = 1'b1;
                        n_state             = S_HRD;
                    end else if (i_stat.placed) begin
                        n_state = S_HNT_R;
                    end else begin
                        o_cmd_bus.scan_init = 1'b1;
                        n_state             = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                o_cmd_bus.fit_start_scan = 1'b1;
                n_state                  = S_FRD;
            end
            S_FRD, S_FCHK: begin
                if (r_state == S_FRD && !i_stat.rect_oob) begin
                    o_cmd_bus.cell_rd_rect = 1'b1;
                    n_state                = S_FCHK;
                end else if (r_state == S_FCHK && !i_stat.occ_q) begin
                    if (i_stat.rect_last) begin
                        o_cmd_bus.rect_restart = 1'b1;
                        n_state                = S_MARK;
                    end else begin
                        o_cmd_bus.rect_next = 1'b1;
                        n_state             = S_FRD;
                    end
                end else if (!i_stat.in_scan) begin
                    // hint position does not fit
                    if (!i_stat.walk_last) begin
                        o_cmd_bus.walk_next = 1'b1;
                        n_state             = S_HRD;
                    end else begin
                        o_cmd_bus.scan_init = 1'b1;
                        n_state             = S_SCAN;
                    end
                end else if (i_stat.scan_last) begin
                    o_cmd_bus.set_status = 1'b1;
                    o_cmd_bus.status     = ST_NO_SPACE;
                    n_state              = S_DONE;
                end else begin
                    o_cmd_bus.scan_next = 1'b1;
                    n_state             = S_SCAN;
                end
            end
            S_MARK: begin
                o_cmd_bus.mark_wr = 1'b1;
                if (!i_stat.rect_last) begin
                    o_cmd_bus.rect_next = 1'b1;
                end else begin
                    o_cmd_bus.place = 1'b1;
                    if (i_stat.in_scan) begin
                        n_state = S_HNT_R;
                    end else begin
                        o_cmd_bus.hint_clr = 1'b1;
                        if (i_stat.walk_last) begin
                            n_state = S_HNT_R;
                        end else begin
                            o_cmd_bus.walk_next = 1'b1;
                            n_state             = S_HRD;
                        end
                    end
                end
            end
            S_HNT_R: begin
                o_cmd_bus.set_status     = 1'b1;
                o_cmd_bus.status         = ST_PLACED;
                o_cmd_bus.hint_set_right = i_stat.right_ok;
                n_state                  = S_HNT_B;
            end
            S_HNT_B: begin
                o_cmd_bus.hint_set_below = i_stat.below_ok;
                n_state                  = S_DONE;
            end
            S_FREE_RD: begin
                o_cmd_bus.cell_rd_rect = 1'b1;
                n_state                = S_FREE_WR;
            end
            S_FREE_WR: begin
                o_cmd_bus.free_wr = 1'b1;
                if (i_stat.rect_last) begin
                    n_state = S_FREE_HNT;
                end else begin
                    o_cmd_bus.rect_next = 1'b1;
                    n_state             = S_FREE_RD;
                end
            end
            S_FREE_HNT: begin
                o_cmd_bus.hint_set_free = 1'b1;
                o_cmd_bus.free_status   = 1'b1;
                n_state                 = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd_bus.emit = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_mark_after_fit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MARK) |-> ($past(r_state) == S_FCHK || $past(r_state) == S_MARK))
        else $error("mark entered without a fit check");
    a_scan_only_unplaced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_bus.scan_init |-> !i_stat.placed)
        else $error("scan started after placement");
    a_free_hint_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FREE_HNT) |=> (r_state == S_DONE))
        else $error("free sequence did not finish");

endmodule

>>> rtl/core/grid_rectangle_block_allocator.sv
// top level of the grid rectangle block allocator
// Allocates and frees rectangles of blocks on a square grid of up to 16 x 16
// cells. One request is worked at a time: a request is taken only when the
// sequencer is idle, though a finished result may still be waiting in the
// output register. Every cell and hint lookup is a registered memory read. An
// allocate walks all 256 hint indexes, then checks candidate positions cell by
// cell; when no hint fits, a first-fit scan over up to side*side positions
// follows. A free reads and clears each cell of the rectangle in turn, then
// sets a hint at its corner. After reset a clearing pass over all 256 cells
// wipes the grid and hint set; no request is taken during it, while grid_side
// writes are taken at any time.
module grid_rectangle_block_allocator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_we,
    input  logic [grba_pkg::SIDE_W-1:0]         i_cfg_data,
    // request channel
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_cmd,
    input  logic [grba_pkg::SIZE_W-1:0]         i_width_blocks,
    input  logic [grba_pkg::SIZE_W-1:0]         i_height_blocks,
    input  logic signed [grba_pkg::SIZE_W-1:0]  i_free_x,
    input  logic signed [grba_pkg::SIZE_W-1:0]  i_free_y,
    input  logic [grba_pkg::ID_W-1:0]           i_owner_id,
    // result channel
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [grba_pkg::STATUS_W-1:0]       o_status,
    output logic [grba_pkg::COORD_W-1:0]        o_placed_x,
    output logic [grba_pkg::COORD_W-1:0]        o_placed_y
);
    import grba_pkg::*;

    t_cmd  cmd_bus;
    t_stat stat;

    // sequencer
    grba_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_stat      (stat),
        .i_req_valid (i_valid),
        .o_req_ready (o_ready),
        .o_cmd_bus   (cmd_bus)
    );

    // memories, counters and result register
    grba_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_bus       (cmd_bus),
        .o_stat          (stat),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_cmd           (i_cmd),
        .i_width_blocks  (i_width_blocks),
        .i_height_blocks (i_height_blocks),
        .i_free_x        (i_free_x),
        .i_free_y        (i_free_y),
        .i_owner_id      (i_owner_id),
        .i_out_ready     (i_ready),
        .o_out_valid     (o_valid),
        .o_status        (o_status),
        .o_placed_x      (o_placed_x),
        .o_placed_y      (o_placed_y)
    );

endmodule
